/* src/tsa_pkg.sv */
// shared constants, types and the reciprocal table of the taylor sine block
// no dependencies; used by tsa_csr, tsa_digit_mul, taylor_sine_approximator and its testbench
package tsa_pkg;

   // field widths
   localparam int ANGLE_W = 31;
   localparam int SINE_W = 48;
   localparam int POWER_W = 5;
   localparam int MAX_POWER_DEF = 31;
   localparam logic [POWER_W-1:0] MAX_POWER_RST = 5'd7;

   // series datapath widths
   localparam int TERM_W = 47;
   localparam int X2_W = 41;
   localparam int RECIP_W = 32;
   localparam int TERM0_SHIFT = 6;
   localparam int SQ_SHIFT = 20;
   localparam int FRAC_SHIFT = 32;
   localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
   localparam logic [SINE_W-1:0] SUM_MAX = {1'b0, {(SINE_W-1){1'b1}}};
   localparam logic [SINE_W-1:0] SUM_MIN = {1'b1, {(SINE_W-1){1'b0}}};

   // digit-serial multiplier
   localparam int DIGIT_W = 4;
   localparam int MCAND_W = 56;
   localparam int MPLIER_W = 44;
   localparam int PROD_W = MCAND_W + MPLIER_W;
   localparam int MUL_DIGITS = MPLIER_W / DIGIT_W;
   localparam int MUL_CNT_W = $clog2(MUL_DIGITS);

   // configuration port
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;
   localparam int REG_IDX_W = APB_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_POWER = 1'b0;

   typedef struct packed {
      logic                load;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   // round(2^32 / ((n+1)(n+2))) for odd n, indexed by n >> 1
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] idx);
      logic [RECIP_W-1:0] r;
      unique case (idx)
         4'd0:  r = 32'd715827883;
         4'd1:  r = 32'd214748365;
         4'd2:  r = 32'd102261126;
         4'd3:  r = 32'd59652324;
         4'd4:  r = 32'd39045157;
         4'd5:  r = 32'd27531842;
         4'd6:  r = 32'd20452225;
         4'd7:  r = 32'd15790321;
         4'd8:  r = 32'd12558384;
         4'd9:  r = 32'd10226113;
         4'd10: r = 32'd8488078;
         4'd11: r = 32'd7158279;
         4'd12: r = 32'd6118187;
         4'd13: r = 32'd5289369;
         4'd14: r = 32'd4618244;
         4'd15: r = 32'd4067204;
      endcase
      return r;
   endfunction

endpackage

/* src/taylor_sine_approximator.sv */
// taylor series sine: odd terms up to L = min(max_power, MAX_POWER), Q5.26 in, Q16.32 out
// one word at a time; each product is a load followed by the digit steps on the shared
// 44-bit multiplier; each further term needs two products and an accumulate step;
// busy drops with the strobe
// synchronous active-high reset: idle, no strobe, max_power = 7
// depends on tsa_pkg, tsa_csr and tsa_digit_mul
module taylor_sine_approximator #(
   parameter int MAX_POWER = tsa_pkg::MAX_POWER_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [tsa_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                rsp_strobe,
   output logic signed [tsa_pkg::SINE_W-1:0]   rsp_sine_estimate,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tsa_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [tsa_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [tsa_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                pready
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_SQUARE    = 5'b00010,
      ST_ACCUM     = 5'b00100,
      ST_MUL_X2    = 5'b01000,
      ST_MUL_RECIP = 5'b10000
   } state_type;

   localparam int SW = tsa_pkg::SINE_W;

   state_type                     state_ff, state_in;
   logic                          neg_ff, neg_in;
   logic [tsa_pkg::POWER_W-1:0]   lim_ff, lim_in;
   logic [tsa_pkg::POWER_W-1:0]   n_ff, n_in;
   logic [tsa_pkg::TERM_W-1:0]    term_ff, term_in;
   logic [tsa_pkg::X2_W-1:0]      x2_ff, x2_in;
   logic [SW-1:0]                 sum_ff, sum_in;
   logic                          sat_ff, sat_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [SW-1:0]                 rsp_sine_ff, rsp_sine_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   logic [tsa_pkg::POWER_W-1:0]   max_power;
   logic [tsa_pkg::POWER_W-1:0]   lim_sel;
   logic [tsa_pkg::ANGLE_W-1:0]   angle_raw;
   logic [tsa_pkg::ANGLE_W-1:0]   angle_mag;
   logic                          angle_neg;
   logic [tsa_pkg::POWER_W:0]     n_plus2;
   logic [SW:0]                   sum_wide;
   logic                          sum_ovf;
   logic [SW-1:0]                 sum_next;
   logic                          term_ovf;

   tsa_pkg::mul_cmd_type          mul_cmd;
   tsa_pkg::mul_rsp_type          mul_rsp;

   tsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .max_power (max_power)
   );

   tsa_digit_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_cmd (mul_cmd),
      .mul_rsp (mul_rsp)
   );

   assign busy = (state_ff != ST_IDLE);

   // magnitude of the angle; two's complement negate is exact for nonzero negatives
   assign angle_raw = req_angle;
   assign angle_neg = angle_raw[tsa_pkg::ANGLE_W-1];
   assign angle_mag = angle_neg ? (~angle_raw + 1'b1) : angle_raw;

   assign lim_sel = ({1'b0, max_power} < (tsa_pkg::POWER_W+1)'(MAX_POWER))
                  ? max_power : tsa_pkg::POWER_W'(MAX_POWER);

   assign n_plus2 = {1'b0, n_ff} + (tsa_pkg::POWER_W+1)'(2);

   // signed accumulate with clamp to the 48-bit range
   always_comb begin
      if (neg_ff) begin
         sum_wide = {sum_ff[SW-1], sum_ff} - (SW+1)'(term_ff);
      end else begin
         sum_wide = {sum_ff[SW-1], sum_ff} + (SW+1)'(term_ff);
      end
      sum_ovf = sum_wide[SW] ^ sum_wide[SW-1];
      if (sum_ovf) begin
         sum_next = sum_wide[SW] ? tsa_pkg::SUM_MIN : tsa_pkg::SUM_MAX;
      end else begin
         sum_next = sum_wide[SW-1:0];
      end
   end

   // any product bit at or above 2^47 after the fraction shift clamps the term
   assign term_ovf = |mul_rsp.prod[tsa_pkg::PROD_W-1:tsa_pkg::FRAC_SHIFT+tsa_pkg::TERM_W];

   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      lim_in        = lim_ff;
      n_in          = n_ff;
      term_in       = term_ff;
      x2_in         = x2_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      rsp_strobe_in = 1'b0;
      rsp_sine_in   = rsp_sine_ff;
      rsp_sat_in    = rsp_sat_ff;
      mul_cmd.load   = 1'b0;
      mul_cmd.mcand  = tsa_pkg::MCAND_W'(term_ff);
      mul_cmd.mplier = tsa_pkg::MPLIER_W'(x2_ff);
      unique case (state_ff)
         ST_IDLE: begin
            mul_cmd.mcand  = tsa_pkg::MCAND_W'(angle_mag);
            mul_cmd.mplier = tsa_pkg::MPLIER_W'(angle_mag);
            if (start) begin
               mul_cmd.load = 1'b1;
               neg_in   = angle_neg;
               lim_in   = lim_sel;
               n_in     = tsa_pkg::POWER_W'(1);
               term_in  = {(tsa_pkg::TERM_W-tsa_pkg::TERM0_SHIFT)'(angle_mag),
                           {tsa_pkg::TERM0_SHIFT{1'b0}}};
               sum_in   = '0;
               sat_in   = 1'b0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_rsp.done) begin
               x2_in = mul_rsp.prod[tsa_pkg::SQ_SHIFT+tsa_pkg::X2_W-1:tsa_pkg::SQ_SHIFT];
               if (lim_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_sine_in   = sum_ff;
                  rsp_sat_in    = sat_ff;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            sum_in = sum_next;
            sat_in = sat_ff | sum_ovf;
            if (n_plus2 <= {1'b0, lim_ff}) begin
               // |term| * x^2, fraction shift in the upper product bits
               mul_cmd.load = 1'b1;
               state_in     = ST_MUL_X2;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_sine_in   = sum_next;
               rsp_sat_in    = sat_ff | sum_ovf;
               state_in      = ST_IDLE;
            end
         end
         ST_MUL_X2: begin
            mul_cmd.mcand  = mul_rsp.prod[tsa_pkg::PROD_W-13:tsa_pkg::FRAC_SHIFT];
            mul_cmd.mplier = tsa_pkg::MPLIER_W'(tsa_pkg::recip(n_ff[tsa_pkg::POWER_W-1:1]));
            if (mul_rsp.done) begin
               mul_cmd.load = 1'b1;
               state_in     = ST_MUL_RECIP;
            end
         end
         ST_MUL_RECIP: begin
            if (mul_rsp.done) begin
               term_in = term_ovf ? tsa_pkg::TERM_MAX
                  : mul_rsp.prod[tsa_pkg::FRAC_SHIFT+tsa_pkg::TERM_W-1:tsa_pkg::FRAC_SHIFT];
               sat_in   = sat_ff | term_ovf;
               neg_in   = !neg_ff;
               n_in     = n_plus2[tsa_pkg::POWER_W-1:0];
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      lim_ff      <= lim_in;
      n_ff        <= n_in;
      term_ff     <= term_in;
      x2_ff       <= x2_in;
      sum_ff      <= sum_in;
      sat_ff      <= sat_in;
      rsp_sine_ff <= rsp_sine_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_sine_estimate = rsp_sine_ff;
   assign rsp_saturated     = rsp_sat_ff;

`ifndef ASSERT_OFF
   a_done_with_strobe : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result strobe");

   a_strobe_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a word is still in work");

   a_mul_done_expected : assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_SQUARE || state_ff == ST_MUL_X2
                        || state_ff == ST_MUL_RECIP))
      else $error("multiplier finished while the sequencer was not waiting");

   a_start_goes_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted word did not start the series");
`endif

endmodule

/* src/tsa_csr.sv */
// configuration register block: apb-style write/read of max_power
// depends on tsa_pkg
module tsa_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tsa_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [tsa_pkg::APB_DATA_W-1:0] pwdata,
   output logic [tsa_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [tsa_pkg::POWER_W-1:0]    max_power
);

   logic [tsa_pkg::POWER_W-1:0] max_power_ff;
   logic [tsa_pkg::POWER_W-1:0] max_power_in;
   logic                        reg_sel;
   logic                        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[tsa_pkg::APB_ADDR_W-1:2] == tsa_pkg::REG_MAX_POWER);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      max_power_in = max_power_ff;
      if (wr_en && reg_sel) begin
         max_power_in = pwdata[tsa_pkg::POWER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff <= tsa_pkg::MAX_POWER_RST;
      end else begin
         max_power_ff <= max_power_in;
      end
   end

   assign prdata = reg_sel
      ? {{(tsa_pkg::APB_DATA_W-tsa_pkg::POWER_W){1'b0}}, max_power_ff}
      : '0;
   assign max_power = max_power_ff;

endmodule

/* src/tsa_digit_mul.sv */
// digit-serial unsigned multiplier, one 4-bit multiplier digit per cycle
// depends on tsa_pkg; product register shifts right as the multiplier is consumed
module tsa_digit_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  tsa_pkg::mul_cmd_type mul_cmd,
   output tsa_pkg::mul_rsp_type mul_rsp
);

   localparam int SUM_W = tsa_pkg::MCAND_W + tsa_pkg::DIGIT_W;

   logic [tsa_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [tsa_pkg::MCAND_W-1:0]   mcand_ff, mcand_in;
   logic [tsa_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [tsa_pkg::DIGIT_W-1:0]   digit;
   logic [SUM_W-1:0]              partial;

   assign digit = prod_ff[tsa_pkg::DIGIT_W-1:0];
   // upper 56 product bits plus multiplicand times the lowest unconsumed digit
   assign partial = {{tsa_pkg::DIGIT_W{1'b0}}, prod_ff[tsa_pkg::PROD_W-1:tsa_pkg::MPLIER_W]}
                  + SUM_W'(mcand_ff) * SUM_W'(digit);

   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (mul_cmd.load) begin
         prod_in  = {{tsa_pkg::MCAND_W{1'b0}}, mul_cmd.mplier};
         mcand_in = mul_cmd.mcand;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         prod_in = {partial, prod_ff[tsa_pkg::MPLIER_W-1:tsa_pkg::DIGIT_W]};
         if (cnt_ff == tsa_pkg::MUL_CNT_W'(tsa_pkg::MUL_DIGITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = prod_ff;

endmodule

/* dv/tb_taylor_sine_approximator.sv */
// self-checking testbench of taylor_sine_approximator: directed and random angles
// through the command port, max_power changed over the apb port between runs
// depends on tsa_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_taylor_sine_approximator;

   localparam int SERIES_CAP = tsa_pkg::MAX_POWER_DEF;
   localparam int TEN_RAD = 671088640;
   localparam int RUN_WORDS = 135;
   localparam int TAIL_CYCLES = 400;

   typedef struct packed {
      logic [tsa_pkg::SINE_W-1:0] estimate;
      logic                       saturated;
   } sine_word_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic signed [tsa_pkg::ANGLE_W-1:0]  req_angle = '0;
   logic                                rsp_strobe;
   logic signed [tsa_pkg::SINE_W-1:0]   rsp_sine_estimate;
   logic                                rsp_saturated;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [tsa_pkg::APB_ADDR_W-1:0]      paddr = '0;
   logic [tsa_pkg::APB_DATA_W-1:0]      pwdata = '0;
   logic [tsa_pkg::APB_DATA_W-1:0]      prdata;
   logic                                pready;

   logic [tsa_pkg::ANGLE_W-1:0]  angle_backlog[$];
   sine_word_type                sine_due[$];
   sine_word_type                got_word;
   logic [tsa_pkg::POWER_W-1:0]  power_cfg = tsa_pkg::MAX_POWER_RST;
   int                           send_idle_pct = 22;
   int                           mismatches = 0;

   logic signed [tsa_pkg::ANGLE_W-1:0] edge_angles[12] = '{
      31'sd0, 31'sd1, -31'sd1, 31'sd671088640, -31'sd671088640, 31'sh3FFF_FFFF,
      31'sh4000_0000, 31'sd105414357, -31'sd210828714, 31'sd67108864,
      -31'sd335544320, 31'sd1000
   };
   logic [tsa_pkg::POWER_W-1:0] phase_powers[9] = '{
      5'd0, 5'd1, 5'd2, 5'd31, 5'd3, 5'd30, 5'd15, 5'd16, 5'd7
   };

   taylor_sine_approximator dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_angle         (req_angle),
      .rsp_strobe        (rsp_strobe),
      .rsp_sine_estimate (rsp_sine_estimate),
      .rsp_saturated     (rsp_saturated),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor(a * b / 2^32), pinned to all ones when it needs more than 64 bits
   function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> tsa_pkg::FRAC_SHIFT;
      return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
   endfunction

   // 1/((n+1)(n+2)) in Q0.32, rounded to nearest
   function automatic logic [63:0] inv_pair(input logic [63:0] n);
      logic [63:0] d;
      d = (n + 64'd1) * (n + 64'd2);
      return ((64'd1 << 33) / d + 64'd1) >> 1;
   endfunction

   function automatic sine_word_type taylor_sine(input logic [tsa_pkg::ANGLE_W-1:0] angle,
                                                 input logic [tsa_pkg::POWER_W-1:0] pwr);
      logic          neg;
      logic          clamped;
      logic [63:0]   mag;
      logic [63:0]   x2;
      logic [63:0]   term;
      longint        acc;
      int            lim;
      sine_word_type w;
      neg = angle[tsa_pkg::ANGLE_W-1];
      mag = neg ? ((64'd1 << tsa_pkg::ANGLE_W) - {33'd0, angle}) : {33'd0, angle};
      lim = (int'(pwr) < SERIES_CAP) ? int'(pwr) : SERIES_CAP;
      x2 = (mag * mag) >> tsa_pkg::SQ_SHIFT;
      term = mag << tsa_pkg::TERM0_SHIFT;
      acc = 0;
      clamped = 1'b0;
      for (int n = 1; n <= lim; n += 2) begin
         acc = neg ? acc - longint'(term) : acc + longint'(term);
         if (acc > longint'({16'd0, tsa_pkg::SUM_MAX})) begin
            acc = longint'({16'd0, tsa_pkg::SUM_MAX});
            clamped = 1'b1;
         end else if (acc < -longint'({16'd0, tsa_pkg::SUM_MAX}) - 1) begin
            acc = -longint'({16'd0, tsa_pkg::SUM_MAX}) - 1;
            clamped = 1'b1;
         end
         if (n + 2 <= lim) begin
            term = frac_mul(frac_mul(term, x2), inv_pair(64'(n)));
            if (term > {17'd0, tsa_pkg::TERM_MAX}) begin
               term = {17'd0, tsa_pkg::TERM_MAX};
               clamped = 1'b1;
            end
            neg = !neg;
         end
      end
      w.estimate = acc[tsa_pkg::SINE_W-1:0];
      w.saturated = clamped;
      return w;
   endfunction

   function automatic logic [tsa_pkg::ANGLE_W-1:0] draw_angle();
      int unsigned pick;
      int          v;
      logic [31:0] raw;
      pick = $urandom_range(99);
      if (pick < 60) begin
         v = int'($urandom_range(2 * TEN_RAD)) - TEN_RAD;
      end else if (pick < 75) begin
         // anything up to +-16 rad
         raw = $urandom;
         v = int'(raw);
      end else if (pick < 85) begin
         v = int'($urandom_range(1 << 20));
         if ($urandom_range(1)) v = -v;
      end else if (pick < 95) begin
         v = TEN_RAD + int'($urandom_range(4096)) - 2048;
         if ($urandom_range(1)) v = -v;
      end else begin
         // close to the ends of the 31-bit range
         v = (1 << 30) - 1 - int'($urandom_range(4096));
         if ($urandom_range(1)) v = -v - 1;
      end
      return tsa_pkg::ANGLE_W'(v);
   endfunction

   // driver: hold a word until taken, predict at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_angle <= '0;
      end else begin
         if (start && !busy) begin
            sine_due.push_back(taylor_sine(req_angle, power_cfg));
         end
         if (!start || !busy) begin
            if (angle_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               start <= 1'b1;
               req_angle <= angle_backlog.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sine_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: sine %h sat %b", rsp_sine_estimate, rsp_saturated);
            end
         end else begin
            got_word = sine_due.pop_front();
            if (rsp_sine_estimate !== got_word.estimate ||
                rsp_saturated !== got_word.saturated) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: sine exp %h got %h, sat exp %b got %b",
                           got_word.estimate, rsp_sine_estimate,
                           got_word.saturated, rsp_saturated);
               end
            end
         end
      end
   end

   task automatic drain_series();
      while (angle_backlog.size() != 0 || start || sine_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_power(input logic [tsa_pkg::POWER_W-1:0] pwr);
      logic [tsa_pkg::APB_DATA_W-1:0] data;
      data = $urandom;
      data[tsa_pkg::POWER_W-1:0] = pwr;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {tsa_pkg::REG_MAX_POWER, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      power_cfg = pwr;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner angles at the reset setting, then with the longest series
      foreach (edge_angles[i]) angle_backlog.push_back(edge_angles[i]);
      drain_series();
      write_power(5'd31);
      foreach (edge_angles[i]) angle_backlog.push_back(edge_angles[i]);
      drain_series();

      for (int p = 0; p < 12; p++) begin
         send_idle_pct = (p < 4) ? 22 : ((p < 8) ? 64 : 0);
         write_power((p < 9) ? phase_powers[p] : tsa_pkg::POWER_W'($urandom_range(31)));
         for (int i = 0; i < RUN_WORDS; i++) angle_backlog.push_back(draw_angle());
         drain_series();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && sine_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
